// ----- rtl/tcsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tcsm_pkg;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned Q_DEPTH    = 2;
	localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] FLAG_FIN = 8'h01;
	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_ACK = 8'h10;

	localparam int unsigned FIN_BIT = 0;
	localparam int unsigned SYN_BIT = 1;
	localparam int unsigned ACK_BIT = 4;

	// reset values of the configuration registers
	localparam logic        RST_ACTIVE_OPEN  = 1'b0;
	localparam logic [31:0] RST_INITIAL_SEQ  = 32'd1;
	localparam logic [15:0] RST_ADV_WINDOW   = 16'd0;
	localparam logic [15:0] RST_RCV_WIN_LEN  = 16'd3072;
	localparam logic [15:0] RST_SEGMENT_SIZE = 16'd536;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_ACTIVE_OPEN        = 3'd0,
		CFG_INITIAL_SEQ        = 3'd1,
		CFG_ADVERTISED_WINDOW  = 3'd2,
		CFG_RECEIVE_WINDOW_LEN = 3'd3,
		CFG_SEGMENT_SIZE       = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_OPEN  = 2'd0,
		OP_SEG   = 2'd1,
		OP_DATA  = 2'd2,
		OP_CLOSE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLOSED         = 4'd0,
		ST_LISTEN         = 4'd1,
		ST_SYN_RCVD       = 4'd2,
		ST_SYN_SENT       = 4'd3,
		ST_ESTAB          = 4'd4,
		ST_FIN_WAIT1      = 4'd5,
		ST_FIN_WAIT2      = 4'd6,
		ST_TIME_WAIT      = 4'd7,
		ST_CLOSING        = 4'd8,
		ST_REMOTE_CLOSED  = 4'd9,
		ST_FINAL_ACK_WAIT = 4'd10
	} conn_state_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_OPEN_ACTIVE,
		ACT_OPEN_PASSIVE,
		ACT_SS_SHRINK,
		ACT_SS_EST,
		ACT_LS_SYN,
		ACT_SR_EST,
		ACT_FIN_EST,
		ACT_FW1_ACK,
		ACT_FW2_FIN,
		ACT_LA_ACK,
		ACT_DELIVER,
		ACT_DATA_ACK,
		ACT_CLOSE_CW,
		ACT_CLOSE_EST
	} act_t;

	typedef struct packed {
		logic        active_open;
		logic [31:0] initial_seq;
		logic [15:0] advertised_window;
		logic [15:0] receive_window_len;
		logic [15:0] segment_size;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  seg_flags;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic [15:0] seg_win;
	} evt_t;

	typedef struct packed {
		logic        send_segment;
		logic [7:0]  out_flags;
		logic [31:0] out_seq;
		logic [31:0] out_ack;
		logic [15:0] out_win;
		logic        deliver_data;
		logic        fin_notify;
		logic        unblock_app;
		logic        conn_done;
		logic [3:0]  conn_state;
	} res_t;

	// classified event handed from front end to back end
	typedef struct packed {
		op_t         op;
		logic        fin;
		logic        syn;
		logic        ackf;
		logic        ack_ok;
		logic [31:0] seq;
		logic [31:0] seq_p1;
		logic [31:0] seq_p_mss;
		logic [31:0] ack;
		logic [15:0] win;
	} cls_t;

endpackage
`default_nettype wire

// ----- rtl/tcsm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcsm_front (
	input  wire tcsm_pkg::evt_t evt,
	input  wire tcsm_pkg::cfg_t cfg,
	output tcsm_pkg::cls_t      cls
);
	import tcsm_pkg::*;

	// state-independent part of the event: decode, handshake ack check,
	// and the two candidate next-ack values
	always_comb begin
		cls.op        = op_t'(evt.op);
		cls.fin       = evt.seg_flags[FIN_BIT];
		cls.syn       = evt.seg_flags[SYN_BIT];
		cls.ackf      = evt.seg_flags[ACK_BIT];
		cls.ack_ok    = (evt.seg_ack == (cfg.initial_seq + 32'd1));
		cls.seq       = evt.seg_seq;
		cls.seq_p1    = evt.seg_seq + 32'd1;
		cls.seq_p_mss = evt.seg_seq + {16'd0, cfg.segment_size};
		cls.ack       = evt.seg_ack;
		cls.win       = evt.seg_win;
	end

endmodule
`default_nettype wire

// ----- rtl/tcsm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcsm_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire tcsm_pkg::cls_t push_data,
	output logic                full,
	input  wire                 pop,
	output logic                not_empty,
	output tcsm_pkg::cls_t      pop_data
);
	import tcsm_pkg::*;

	cls_t                 entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/tcsm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcsm_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire tcsm_pkg::cfg_t cfg,
	input  wire                 cls_valid,
	input  wire tcsm_pkg::cls_t cls,
	output logic                cls_pop,
	output logic                res_valid,
	input  wire                 res_ready,
	output tcsm_pkg::res_t      res
);
	import tcsm_pkg::*;

	conn_state_t state_q, state_d;
	logic [31:0] nss_q, nss_d;
	logic [31:0] nea_q, nea_d;
	logic [15:0] sw_q, sw_d;
	logic        finished_q, finished_d;
	logic        res_valid_q;
	res_t        res_q, res_d;

	act_t        act;
	logic        in_loop;
	logic [31:0] limit;
	logic        beyond;
	logic [15:0] sw_min;

	assign cls_pop   = cls_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign in_loop = (state_q >= ST_ESTAB) && !finished_q;
	assign limit   = nea_q + {16'd0, cfg.receive_window_len} - 32'd1;
	assign beyond  = (limit < cls.seq);
	assign sw_min  = (cls.win < sw_q) ? cls.win : sw_q;

	// pick what this event does
	always_comb begin
		act = ACT_NONE;
		unique case (cls.op)
			OP_OPEN: begin
				act = cfg.active_open ? ACT_OPEN_ACTIVE : ACT_OPEN_PASSIVE;
			end
			OP_SEG: begin
				priority if (state_q == ST_SYN_SENT) begin
					act = (cls.syn && cls.ackf && cls.ack_ok) ? ACT_SS_EST : ACT_SS_SHRINK;
				end else if (state_q == ST_LISTEN) begin
					if (cls.syn) act = ACT_LS_SYN;
				end else if (state_q == ST_SYN_RCVD) begin
					if (cls.ackf && cls.ack_ok) act = ACT_SR_EST;
				end else if (in_loop) begin
					priority if (beyond) begin
						act = ACT_NONE;
					end else if (cls.fin && state_q == ST_ESTAB) begin
						act = ACT_FIN_EST;
					end else if (cls.ackf && state_q == ST_FIN_WAIT1) begin
						act = ACT_FW1_ACK;
					end else if (cls.fin && state_q == ST_FIN_WAIT2) begin
						act = ACT_FW2_FIN;
					end else if (cls.ackf && state_q == ST_FINAL_ACK_WAIT) begin
						act = ACT_LA_ACK;
					end else begin
						act = ACT_DELIVER;
					end
				end else begin
					act = ACT_NONE;
				end
			end
			OP_DATA: begin
				if (in_loop) act = ACT_DATA_ACK;
			end
			OP_CLOSE: begin
				if (in_loop && state_q == ST_REMOTE_CLOSED) begin
					act = ACT_CLOSE_CW;
				end else if (in_loop && state_q == ST_ESTAB) begin
					act = ACT_CLOSE_EST;
				end
			end
			default: act = ACT_NONE;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (act)
			ACT_OPEN_ACTIVE:  state_d = ST_SYN_SENT;
			ACT_OPEN_PASSIVE: state_d = ST_LISTEN;
			ACT_SS_EST:       state_d = ST_ESTAB;
			ACT_LS_SYN:       state_d = ST_SYN_RCVD;
			ACT_SR_EST:       state_d = ST_ESTAB;
			ACT_FIN_EST:      state_d = ST_REMOTE_CLOSED;
			ACT_FW1_ACK:      state_d = ST_FIN_WAIT2;
			ACT_FW2_FIN:      state_d = ST_CLOSED;
			ACT_LA_ACK:       state_d = ST_CLOSED;
			ACT_CLOSE_CW:     state_d = ST_FINAL_ACK_WAIT;
			ACT_CLOSE_EST:    state_d = ST_FIN_WAIT1;
			default:          state_d = state_q;
		endcase
	end

	// sequence/window registers and the result
	always_comb begin
		nss_d      = nss_q;
		nea_d      = nea_q;
		sw_d       = sw_q;
		finished_d = finished_q;
		res_d      = '0;
		unique case (act)
			ACT_OPEN_ACTIVE: begin
				nss_d              = cfg.initial_seq;
				nea_d              = '0;
				sw_d               = '0;
				finished_d         = 1'b0;
				res_d.send_segment = 1'b1;
				res_d.out_flags    = FLAG_SYN;
				res_d.out_seq      = cfg.initial_seq;
				res_d.out_win      = cfg.advertised_window;
			end
			ACT_OPEN_PASSIVE: begin
				nss_d      = cfg.initial_seq;
				nea_d      = '0;
				sw_d       = '0;
				finished_d = 1'b0;
			end
			ACT_SS_SHRINK: begin
				sw_d = sw_min;
			end
			ACT_SS_EST: begin
				sw_d               = sw_min;
				nea_d              = cls.seq_p1;
				nss_d              = cls.ack;
				res_d.send_segment = 1'b1;
				res_d.out_flags    = FLAG_ACK;
				res_d.out_seq      = cls.ack;
				res_d.out_ack      = cls.seq_p1;
				res_d.out_win      = cfg.advertised_window;
				res_d.unblock_app  = 1'b1;
			end
			ACT_LS_SYN: begin
				sw_d               = sw_min;
				nea_d              = cls.seq_p1;
				res_d.send_segment = 1'b1;
				res_d.out_flags    = FLAG_SYN | FLAG_ACK;
				res_d.out_seq      = cfg.initial_seq;
				res_d.out_ack      = cls.seq_p1;
				res_d.out_win      = cfg.advertised_window;
			end
			ACT_SR_EST: begin
				sw_d              = sw_min;
				nea_d             = cls.seq_p1;
				nss_d             = cls.ack;
				res_d.unblock_app = 1'b1;
			end
			ACT_FIN_EST, ACT_FW2_FIN: begin
				sw_d               = sw_min;
				nea_d              = cls.seq_p1;
				nss_d              = cls.ack;
				res_d.send_segment = 1'b1;
				res_d.out_flags    = FLAG_ACK;
				res_d.out_seq      = cls.ack;
				res_d.out_ack      = cls.seq_p1;
				res_d.out_win      = cfg.advertised_window;
				res_d.fin_notify   = 1'b1;
				if (act == ACT_FW2_FIN) finished_d = 1'b1;
			end
			ACT_FW1_ACK, ACT_LA_ACK: begin
				sw_d  = sw_min;
				nea_d = cls.seq_p1;
				nss_d = cls.ack;
				if (act == ACT_LA_ACK) finished_d = 1'b1;
			end
			ACT_DELIVER: begin
				nea_d              = cls.seq_p_mss;
				res_d.deliver_data = 1'b1;
			end
			ACT_DATA_ACK: begin
				res_d.send_segment = 1'b1;
				res_d.out_flags    = FLAG_ACK;
				res_d.out_seq      = nss_q;
				res_d.out_ack      = nea_q;
				res_d.out_win      = sw_q;
			end
			ACT_CLOSE_CW, ACT_CLOSE_EST: begin
				res_d.send_segment = 1'b1;
				res_d.out_flags    = FLAG_FIN;
				res_d.out_seq      = nss_q;
				res_d.out_ack      = nea_q;
				res_d.out_win      = sw_q;
			end
			default: begin
			end
		endcase
		res_d.conn_done  = finished_d;
		res_d.conn_state = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LISTEN;
			nss_q       <= '0;
			nea_q       <= '0;
			sw_q        <= '0;
			finished_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cls_pop) begin
				state_q    <= state_d;
				nss_q      <= nss_d;
				nea_q      <= nea_d;
				sw_q       <= sw_d;
				finished_q <= finished_d;
			end
			if (cls_pop) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cls_pop) begin
			res_q <= res_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/tcp_connection_state_machine_unit.sv -----
// Connection state keeper for one simplified TCP connection. Each accepted
// event (open, received header, application data, close) yields exactly one
// result transaction carrying the header to send, notifications and the new
// state. One event per cycle is sustained while res_ready is held high; an event
// is decoded by the front end into a two-entry queue, then the back end makes the
// state update, which sets the rate, and registers the result. The queue lets the
// front keep taking events while a result waits, until the queue is full.
// Configuration writes take effect on the next cycle and must be made only
// while no event is in flight.
`timescale 1ns / 1ps
`default_nettype none
module tcp_connection_state_machine_unit (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    evt_valid,
	output logic                                   evt_ready,
	input  wire tcsm_pkg::evt_t                    evt,
	output logic                                   res_valid,
	input  wire                                    res_ready,
	output tcsm_pkg::res_t                         res,
	input  wire                                    cfg_we,
	input  wire [tcsm_pkg::CFG_ADDR_W-1:0]         cfg_addr,
	input  wire [tcsm_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
	import tcsm_pkg::*;

	cfg_t cfg_q;
	cls_t cls_in;
	cls_t cls_out;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	logic push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_open        <= RST_ACTIVE_OPEN;
			cfg_q.initial_seq        <= RST_INITIAL_SEQ;
			cfg_q.advertised_window  <= RST_ADV_WINDOW;
			cfg_q.receive_window_len <= RST_RCV_WIN_LEN;
			cfg_q.segment_size       <= RST_SEGMENT_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_ACTIVE_OPEN:        cfg_q.active_open        <= cfg_wdata[0];
				CFG_INITIAL_SEQ:        cfg_q.initial_seq        <= cfg_wdata;
				CFG_ADVERTISED_WINDOW:  cfg_q.advertised_window  <= cfg_wdata[15:0];
				CFG_RECEIVE_WINDOW_LEN: cfg_q.receive_window_len <= cfg_wdata[15:0];
				CFG_SEGMENT_SIZE:       cfg_q.segment_size       <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	assign evt_ready = !q_full;
	assign push      = evt_valid && !q_full;

	tcsm_front u_front (
		.evt (evt),
		.cfg (cfg_q),
		.cls (cls_in)
	);

	tcsm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (cls_out)
	);

	tcsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cls_valid (q_not_empty),
		.cls       (cls_out),
		.cls_pop   (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
`default_nettype wire
